### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the modular power block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/core/mpow_pkg.sv
// ----------------------------------------------------------------------------
// mpow_pkg
// Types and constants shared by the modular power block.
// ----------------------------------------------------------------------------
package mpow_pkg;
  localparam int unsigned InW    = 31;
  localparam int unsigned OutW   = 30;
  localparam int unsigned ProdW  = 62;
  localparam logic [ProdW-1:0] Modulus = 62'd1000000007;
  // Reduction cells: one per quotient bit, shifts 32 down to 0
  localparam int unsigned NumCells = 33;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StWait,
    StDone
  } state_e;

  typedef struct packed {
    logic             vld;
    logic             is_acc;
    logic [ProdW-1:0] rem;
  } cell_t;
endpackage

### rtl/core/mpow_cell.sv
// ----------------------------------------------------------------------------
// mpow_cell
// One restoring-reduction cell: conditionally subtract a shifted modulus.
// ----------------------------------------------------------------------------
module mpow_cell import mpow_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t cell_i,
  output cell_t cell_o
);
  localparam logic [ProdW+32:0] Sub = {33'd0, Modulus} << Shift;

  cell_t cell_d, cell_q;
  logic [ProdW+32:0] ext;

  always_comb begin
    ext    = {33'd0, cell_i.rem};
    cell_d = cell_i;
    if (ext >= Sub) begin
      cell_d.rem = ProdW'(ext - Sub);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

### rtl/core/mpow_reduce.sv
// ----------------------------------------------------------------------------
// mpow_reduce
// Chain of reduction cells taking a 62-bit product modulo the prime.
// ----------------------------------------------------------------------------
module mpow_reduce import mpow_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t in_i,
  output cell_t out_o
);
  cell_t chain [NumCells+1];

  assign chain[0] = in_i;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    mpow_cell #(.Shift(NumCells - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign out_o = chain[NumCells];
endmodule

### rtl/core/modular_power_prime_modulus.sv
// ----------------------------------------------------------------------------
// modular_power_prime_modulus
// Base to a 31-bit exponent modulo 1000000007 by square and multiply.
// ----------------------------------------------------------------------------
// Input word (base_i, exponent_i) is taken on in_valid_i && in_ready_o while
// the block is idle; one result word power_mod_o follows on out_valid_o.
// Each exponent bit costs one pass: the StMul state registers the square of
// the base and the product of the running result and the base, the square
// then enters a chain of 33 reduction cells with the result product in the
// cycle after it, and both are counted back before the next pass, so the
// depth of that chain sets the length of a pass. A word takes one pass per
// exponent bit up to the top set bit; a zero exponent goes straight to done.
// One item is in flight at a time; the output register holds the result
// while the receiver stalls and the next word is taken once it is drained.
// Reset clears the control state and drops any item in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module modular_power_prime_modulus import mpow_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [InW-1:0]  base_i,
  input  logic [InW-1:0]  exponent_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [OutW-1:0] power_mod_o
);
  state_e state_q, state_d;
  logic [InW-1:0]   exp_q, exp_d;
  logic [InW-1:0]   sq_q, sq_d;
  logic [InW-1:0]   acc_q, acc_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [ProdW-1:0] pa_q, ps_q;
  logic             pv_q;
  logic             pa_use_q;
  cell_t            red_in, red_out;
  logic             start;

  assign start = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start) state_d = (exponent_i == '0) ? StDone : StMul;
      StMul:  state_d = StWait;
      StWait: if (cnt_q == 2'd2) state_d = (exp_q == '0) ? StDone : StMul;
      StDone: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == StIdle);
    out_valid_o = (state_q == StDone);
  end

  // Two reduced values come back on consecutive cycles: square, then result
  always_comb begin
    exp_d = exp_q;
    sq_d  = sq_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (start) begin
      exp_d = exponent_i;
      sq_d  = base_i;
      acc_d = InW'(1);
    end
    if (state_q == StMul) begin
      cnt_d = 2'd0;
      exp_d = exp_q >> 1;
    end
    if (red_out.vld) begin
      cnt_d = cnt_q + 2'd1;
      if (red_out.is_acc) acc_d = InW'(red_out.rem);
      else                sq_d  = InW'(red_out.rem);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= 2'd0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= (state_q == StMul);
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    sq_q  <= sq_d;
    acc_q <= acc_d;
    if (state_q == StMul) begin
      ps_q     <= ProdW'(sq_q) * ProdW'(sq_q);
      pa_q     <= ProdW'(acc_q) * ProdW'(sq_q);
      pa_use_q <= exp_q[0];
    end
  end

  // Square enters first, result product in the next cycle (or the old result)
  logic second_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) second_q <= 1'b0;
    else         second_q <= pv_q;
  end

  always_comb begin
    red_in.vld    = pv_q || second_q;
    red_in.is_acc = second_q;
    red_in.rem    = ps_q;
    if (second_q) red_in.rem = pa_use_q ? pa_q : ProdW'(acc_q);
  end

  mpow_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (red_in),
    .out_o  (red_out)
  );

  assign power_mod_o = OutW'(acc_q);

  `ASSERT_NEVER(a_no_issue_busy, clk_i, rst_ni, pv_q && second_q)
  `ASSERT_IMPL(a_done_in_range, clk_i, rst_ni, out_valid_o |-> (acc_q < InW'(Modulus)))
  `ASSERT_NEVER(a_red_idle, clk_i, rst_ni, red_out.vld && (state_q == StIdle))
  `ASSERT_IMPL(a_hold_out, clk_i, rst_ni,
               (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(power_mod_o)))
endmodule

### tb/sv/power_mod_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// power_mod_checker
// Watches both channels of the modular power block, computes the expected
// power for each accepted input word and compares it with each result word.
// ----------------------------------------------------------------------------
module power_mod_checker import mpow_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [InW-1:0]  base_i,
  input  logic [InW-1:0]  exponent_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [OutW-1:0] power_mod_i,
  output int              err_count_o,
  output int              pending_o
);
  localparam longint unsigned Prime = 64'd1000000007;

  logic [OutW-1:0] want_q[$];

  function automatic logic [OutW-1:0] power_mod_calc(logic [InW-1:0] b, logic [InW-1:0] e);
    longint unsigned sq, acc;
    logic [InW-1:0] rest;
    sq   = {33'd0, b};
    acc  = 1;
    rest = e;
    while (rest != '0) begin
      if (rest[0]) acc = (acc * sq) % Prime;
      sq   = (sq * sq) % Prime;
      rest = rest >> 1;
    end
    return acc[OutW-1:0];
  endfunction

  initial err_count_o = 0;
  assign pending_o = want_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) want_q.push_back(power_mod_calc(base_i, exponent_i));
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          $error("unexpected result word power_mod=%0d", power_mod_i);
          err_count_o <= err_count_o + 1;
        end else begin
          if (power_mod_i !== want_q[0]) begin
            $error("power_mod mismatch: expected %0d, actual %0d", want_q[0], power_mod_i);
            err_count_o <= err_count_o + 1;
          end
          void'(want_q.pop_front());
        end
      end
    end
  end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives base and exponent words into the modular power block, with directed
// corner cases and random words, random stalls on both sides, and a verdict.
// ----------------------------------------------------------------------------
module testbench;
  import mpow_pkg::*;

  localparam int unsigned Prime = 32'd1000000007;
  localparam int NumRand = 530;
  localparam longint CycleLimit = 64'd3000000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [InW-1:0]  base_i = '0;
  logic [InW-1:0]  exponent_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [OutW-1:0] power_mod_o;
  int              err_count;
  int              pending;
  longint          cycles = 0;
  bit              calm = 1'b0;

  always #5 clk_i = ~clk_i;

  modular_power_prime_modulus DUT (.*);

  power_mod_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .base_i, .exponent_i,
    .out_valid_i(out_valid_o), .out_ready_i, .power_mod_i(power_mod_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls in bursts, none once calm
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Valid stays up between back-to-back words; drop it only to idle
  task automatic send_word(int unsigned b, int unsigned e);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_i     <= InW'(b);
    exponent_i <= InW'(e);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly short exponents to keep passes few, a share at full width
  function automatic int unsigned rand_exponent();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return $urandom();
    if (k < 4) return $urandom_range(0, 3);
    return $urandom() & ((32'd1 << $urandom_range(1, 12)) - 32'd1);
  endfunction

  function automatic int unsigned rand_base();
    case ($urandom_range(0, 5))
      0: return Prime - $urandom_range(0, 2);
      1: return Prime + $urandom_range(0, 2);
      2: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Zero exponent, also with zero base and a multiple of the prime
    send_word(0, 0);
    send_word(Prime, 0);
    send_word('1, 0);
    send_word(0, 1);
    send_word(0, '1);
    send_word(1, '1);
    send_word('1, 1);
    send_word('1, '1);
    send_word(Prime, 5);
    send_word(2 * Prime, 3);
    send_word(Prime - 1, 2);
    send_word(Prime - 1, 3);
    send_word(Prime + 1, '1);
    send_word(2, 30);
    send_word(2, 32'h40000000);
    send_word(32'h2AAAAAAA, 32'h55555555);
    send_word(32'h55555555, 32'h2AAAAAAA);
    send_word(Prime - 2, Prime - 2);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    // Hold off until the block has drained
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < NumRand; i++) begin
      if (i == NumRand - 60) calm = 1'b1;
      send_word(rand_base(), rand_exponent());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mpow_pkg.sv
rtl/core/mpow_cell.sv
rtl/core/mpow_reduce.sv
rtl/core/modular_power_prime_modulus.sv
tb/sv/power_mod_checker.sv
tb/sv/testbench.sv
